### rtl/core/cid_pkg.sv
// Package for the compact index decoder: decoder state and result types and
// the field masks of the byte format. Depends on nothing.
package cid_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CountWidth = 3;
    localparam int unsigned PosWidth   = 3;

    localparam logic [7:0] SignFirst = 8'h80;
    localparam logic [7:0] MoreFirst = 8'h40;
    localparam logic [7:0] MoreNext  = 8'h80;
    localparam logic [7:0] Low7Mask  = 8'h7f;
    localparam logic [7:0] Low6Mask  = 8'h3f;

    typedef enum logic [PosWidth-1:0] {
        POS_FIRST  = 3'd0,
        POS_SECOND = 3'd1,
        POS_THIRD  = 3'd2,
        POS_FOURTH = 3'd3,
        POS_FIFTH  = 3'd4
    } t_pos;

    typedef struct packed {
        t_pos                  pos;
        logic [ValueWidth-1:0] mag;
        logic                  neg;
    } t_dec_state;

    typedef struct packed {
        logic                  done;
        logic [ValueWidth-1:0] value;
        logic [CountWidth-1:0] count;
    } t_dec_result;

endpackage

### rtl/core/cid_step.sv
// One decoding step: folds a byte into the decoder state and signals a
// finished value. Purely combinational. Depends on cid_pkg.
module cid_step (
    input  cid_pkg::t_dec_state  i_state,
    input  logic [7:0]           i_byte,
    output cid_pkg::t_dec_state  o_next,
    output cid_pkg::t_dec_result o_result
);
    import cid_pkg::*;

    logic [ValueWidth-1:0] s_mag;
    logic                  s_neg;
    logic                  s_done;
    logic [CountWidth-1:0] s_count;
    t_pos                  s_pos;

    always_comb begin
        s_mag   = i_state.mag;
        s_neg   = i_state.neg;
        s_done  = 1'b0;
        s_count = 3'd1;
        s_pos   = POS_FIRST;
        unique case (i_state.pos)
            POS_SECOND: begin
                s_mag   = i_state.mag | {19'd0, i_byte[6:0], 6'd0};
                s_done  = (i_byte & MoreNext) == 8'd0;
                s_count = 3'd2;
                s_pos   = s_done ? POS_FIRST : POS_THIRD;
            end
            POS_THIRD: begin
                s_mag   = i_state.mag | {12'd0, i_byte[6:0], 13'd0};
                s_done  = (i_byte & MoreNext) == 8'd0;
                s_count = 3'd3;
                s_pos   = s_done ? POS_FIRST : POS_FOURTH;
            end
            POS_FOURTH: begin
                s_mag   = i_state.mag | {5'd0, i_byte[6:0], 20'd0};
                s_done  = (i_byte & MoreNext) == 8'd0;
                s_count = 3'd4;
                s_pos   = s_done ? POS_FIRST : POS_FIFTH;
            end
            POS_FIFTH: begin
                s_mag   = i_state.mag | {i_byte[4:0], 27'd0};
                s_done  = 1'b1;
                s_count = 3'd5;
                s_pos   = POS_FIRST;
            end
            default: begin
                s_neg   = (i_byte & SignFirst) != 8'd0;
                s_mag   = {24'd0, i_byte & Low6Mask};
                s_done  = (i_byte & MoreFirst) == 8'd0;
                s_count = 3'd1;
                s_pos   = s_done ? POS_FIRST : POS_SECOND;
            end
        endcase
    end

    assign o_next.pos     = s_pos;
    assign o_next.mag     = s_mag;
    assign o_next.neg     = s_neg;
    assign o_result.done  = s_done;
    assign o_result.count = s_count;
    assign o_result.value = s_neg ? (~s_mag + 32'd1) : s_mag;

endmodule

### rtl/core/compact_index_decoder_unit.sv
// The result of a byte that ends a value passes through the input register
// and the result register. Throughput: one byte per cycle unless a finished
// value waits for the result register to be taken; the single decoding step
// between the input register and the result register limits the rate.
// Reset: i_rst_n is synchronous and active low; it empties both registers
// and returns the decoder to expecting the first byte of a value.
// Top level of the compact index decoder. Depends on cid_pkg and cid_step.
module compact_index_decoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [cid_pkg::ValueWidth-1:0] o_value,
    output logic [cid_pkg::CountWidth-1:0] o_byte_count
);
    import cid_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    t_dec_state            r_state;
    t_dec_state            n_state;
    t_dec_result           s_result;
    logic                  r_out_valid;
    logic [ValueWidth-1:0] r_value;
    logic [CountWidth-1:0] r_count;
    logic                  s_advance;
    logic                  s_in_take;

    cid_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_next   (n_state),
        .o_result (s_result)
    );

    assign s_advance  = r_in_valid && (!s_result.done || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s_advance;
    assign s_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_take) begin
            r_in_valid <= 1'b1;
        end else if (s_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{pos: POS_FIRST, mag: '0, neg: 1'b0};
        end else if (s_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance && s_result.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_result.done) begin
            r_value <= s_result.value;
            r_count <= s_result.count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_byte_count = r_count;

endmodule

### rtl/core/cid_checker.sv
// Port-level checks for the compact index decoder, attached by a bind
// statement at the end. Depends on cid_pkg and compact_index_decoder_unit.
module cid_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [cid_pkg::ValueWidth-1:0] o_value,
    input logic [cid_pkg::CountWidth-1:0] o_byte_count
);
    import cid_pkg::*;

    // A result beat that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value)
            && $stable(o_byte_count))
        else $error("result beat dropped or changed while stalled");

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_count != 3'd0 && o_byte_count <= 3'd5)
        else $error("byte count out of range");

    // A one-byte value carries at most six magnitude bits.
    a_short_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_count == 3'd1 |->
            o_value[31:6] == 26'd0
            || (o_value[31:6] == 26'h3ffffff && o_value[5:0] != 6'd0))
        else $error("one-byte value exceeds six bits of magnitude");

endmodule

bind compact_index_decoder_unit cid_checker u_cid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_value      (o_value),
    .o_byte_count (o_byte_count)
);

### tb/tb_compact_index_decoder_unit.sv
// Self-checking testbench for compact_index_decoder_unit: a queue-fed driver sends
// encoded bytes, and a monitor compares each decoded value with a local predictor.
// Depends on cid_pkg and the decoder RTL.
module tb_compact_index_decoder_unit;
    import cid_pkg::*;

    typedef struct packed {
        logic [ValueWidth-1:0] value;
        logic [CountWidth-1:0] count;
    } t_decoded;

    localparam int CycleLimit = 200000;
    localparam int RandomBytes = 1200;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [7:0]                   i_data_byte = 8'h00;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [ValueWidth-1:0] o_value;
    logic [CountWidth-1:0]        o_byte_count;

    logic [7:0]      pending_bytes[$];
    t_decoded        due_values[$];
    t_pos            acc_pos = POS_FIRST;
    logic [31:0]     acc_mag = '0;
    logic            acc_neg = 1'b0;
    int              in_wait = 0;
    int              out_wait = 0;
    bit              in_quiet = 1'b0;
    bit              out_quiet = 1'b0;
    int              bytes_accepted = 0;
    int              values_checked = 0;
    int              mismatches = 0;
    int              hold_left = 0;
    bit              hold_used = 1'b0;
    int              cycle_count = 0;

    compact_index_decoder_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value),
        .o_byte_count (o_byte_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [31:0]           mag;
        logic [CountWidth-1:0] cnt;
        bit                    more;
        t_decoded              res;
        mag = acc_mag;
        more = 1'b0;
        case (acc_pos)
            POS_SECOND: begin
                mag = mag | (32'(b & Low7Mask) << 6);
                more = (b & MoreNext) != 0;
                cnt = 3'd2;
                acc_pos = more ? POS_THIRD : POS_FIRST;
            end
            POS_THIRD: begin
                mag = mag | (32'(b & Low7Mask) << 13);
                more = (b & MoreNext) != 0;
                cnt = 3'd3;
                acc_pos = more ? POS_FOURTH : POS_FIRST;
            end
            POS_FOURTH: begin
                mag = mag | (32'(b & Low7Mask) << 20);
                more = (b & MoreNext) != 0;
                cnt = 3'd4;
                acc_pos = more ? POS_FIFTH : POS_FIRST;
            end
            POS_FIFTH: begin
                mag = mag | (32'(b) << 27);
                cnt = 3'd5;
                acc_pos = POS_FIRST;
            end
            default: begin
                acc_neg = (b & SignFirst) != 0;
                mag = 32'(b & Low6Mask);
                more = (b & MoreFirst) != 0;
                cnt = 3'd1;
                acc_pos = more ? POS_SECOND : POS_FIRST;
            end
        endcase
        acc_mag = mag;
        if (!more) begin
            res.value = acc_neg ? (~mag + 32'd1) : mag;
            res.count = cnt;
            due_values.push_back(res);
        end
    endtask

    // Appends one well-formed value of the given length in bytes.
    task automatic add_value(input int len, input bit zero_content);
        logic [7:0] b;
        int         k;
        b = 8'($urandom);
        if (zero_content) b = b & SignFirst;
        b = (len > 1) ? (b | MoreFirst) : (b & ~MoreFirst);
        pending_bytes.push_back(b);
        for (k = 1; k < len; k++) begin
            b = zero_content ? 8'h00 : 8'($urandom);
            if (k < 4) begin
                b = b & Low7Mask;
                if (k < len - 1) b = b | MoreNext;
            end
            pending_bytes.push_back(b);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_data_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_wait != 0) begin
                    in_wait <= in_wait - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    if ($urandom_range(0, 39) == 0) in_quiet = ~in_quiet;
                    i_in_valid <= 1'b1;
                    i_data_byte <= pending_bytes.pop_front();
                    in_wait <= draw_gap(in_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && bytes_accepted >= 400) begin
            hold_left <= 400;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        int       nwait;
        t_decoded exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait <= 0;
        end else begin
            nwait = out_wait;
            if (o_out_valid && i_out_ready) begin
                values_checked++;
                if (due_values.size() == 0) begin
                    $error("unexpected beat: value %0d, byte_count %0d", o_value, o_byte_count);
                    mismatches++;
                end else begin
                    exp_res = due_values.pop_front();
                    if (o_value !== exp_res.value) begin
                        $error("value: expected %0d, actual %0d",
                               $signed(exp_res.value), o_value);
                        mismatches++;
                    end
                    if (o_byte_count !== exp_res.count) begin
                        $error("byte_count: expected %0d, actual %0d",
                               exp_res.count, o_byte_count);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0) out_quiet = ~out_quiet;
                nwait = draw_gap(out_quiet);
            end else if (nwait != 0) begin
                nwait--;
            end
            out_wait <= nwait;
            i_out_ready <= (nwait == 0) && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int pick;
        // Zero, negative zero, the largest one-byte values, then values of every
        // length: a full five-byte pattern that wraps, and the most negative one.
        pending_bytes = {8'h00, 8'h80, 8'h3f, 8'hbf,
                         8'h41, 8'h01,
                         8'hc1, 8'h81, 8'h7f,
                         8'h7f, 8'hff, 8'hff, 8'h7f,
                         8'h7f, 8'hff, 8'hff, 8'hff, 8'hff,
                         8'hc0, 8'h80, 8'h80, 8'h80, 8'h10};
        while (pending_bytes.size() < RandomBytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                add_value($urandom_range(1, 5), $urandom_range(0, 15) == 0);
            end else begin
                repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
            end
        end
        // Close any value left open by the noise bytes.
        repeat (5) pending_bytes.push_back(8'h00);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || due_values.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Sent %0d encoded bytes and checked %0d decoded values, one long output stall.",
                 bytes_accepted, values_checked);
        if (mismatches == 0 && due_values.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/cid_pkg.sv
rtl/core/cid_step.sv
rtl/core/compact_index_decoder_unit.sv
rtl/core/cid_checker.sv
tb/tb_compact_index_decoder_unit.sv
